// ===== hw/rtl/pcbw_pkg.sv =====
// Shared types and constants for the per-client baseline window.
package pcbw_pkg;

  localparam int ID_W        = 32;
  localparam int OPCODE_W    = 3;
  localparam int CLIENT_W    = 4;
  localparam int CFG_W       = 4;
  localparam int CNT_OUT_W   = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OPCODE_W-1:0] OP_STORE  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DECIDE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_LATEST = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_COUNT  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [CFG_W-1:0] CFG_MAX_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_META,
    ST_SCAN,
    ST_LATEST,
    ST_DONE
  } pcbw_state_t;

endpackage

// ===== hw/rtl/per_client_baseline_window.sv =====
// Top level of the per-client baseline window: sequencer, search unit and storage.
//
//   in_*  : one request per transfer; in_tdata holds opcode, client and snapshot_id.
//   out_* : exactly one result per request, in request order: found,
//           baseline_id and the client's window_count after the operation.
//   cfg_* : cfg_wr_en writes max_per_client (a limit above the window depth acts
//           as the depth). Write it only while no request is in flight.
// Structure: per-client pointer and count live in a small RAM, ids in
//   a second RAM with registered read. Store, count, clear and unknown opcodes go
//   from the metadata read straight to the result; latest first reads its id. Decide
//   and find scan the window one stored id per cycle through a single comparator,
//   stopping early on a hit and skipping the scan for an empty window or a decide
//   of zero; the compare-and-advance loop over the id RAM read port sets this pace.
//   A new request is taken once the previous result is in the output register.
// Reset: rst_n low clears control state and the limit (to 8). After reset a sweep
//   over every client slot empties its window; in_tready stays low meanwhile.
// Stall: a result waits in the output register while out_tready is low; the
//   sequencer holds its finished result and takes no new request meanwhile.
module per_client_baseline_window #(
  parameter int CLIENT_SLOTS = 16,
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // config
  input  logic                               cfg_wr_en,
  input  logic [pcbw_pkg::CFG_W-1:0]         cfg_wr_data,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] opcode, [6:3] client, [38:7] snapshot_id, [39] zero
  input  logic [pcbw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] found, [32:1] baseline_id, [36:33] window_count, [39:37] zero
  output logic [pcbw_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int SLOT_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int META_W  = PTR_W + CNT_W;
  localparam int ID_DEPTH = CLIENT_SLOTS * WINDOW_DEPTH;
  localparam int ADDR_W  = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;
  localparam int ID_W    = pcbw_pkg::ID_W;

  // Wrap a position sum back into the circular window (sum stays below 2x depth).
  function automatic logic [PTR_W-1:0] wrap_pos(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = (s >= SUM_W'(WINDOW_DEPTH)) ? s - SUM_W'(WINDOW_DEPTH) : s;
    return t[PTR_W-1:0];
  endfunction

  // Request fields
  logic [pcbw_pkg::OPCODE_W-1:0] in_opcode;
  logic [pcbw_pkg::CLIENT_W-1:0] in_client;
  logic [ID_W-1:0]               in_snapshot_id;

  assign in_opcode      = in_tdata[2:0];
  assign in_client      = in_tdata[6:3];
  assign in_snapshot_id = in_tdata[38:7];

  // Control and payload registers
  pcbw_pkg::pcbw_state_t state_r, state_nxt;
  logic [pcbw_pkg::CFG_W-1:0]    cfg_max_r;
  logic [SLOT_W-1:0]             init_r, init_nxt;
  logic [pcbw_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic [ID_W-1:0]               id_r, id_nxt;
  logic                          ok_r, ok_nxt;
  logic [ADDR_W-1:0]             base_r, base_nxt;
  logic [PTR_W-1:0]              ptr_r, ptr_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              k_r, k_nxt;
  logic                          res_found_r, res_found_nxt;
  logic [ID_W-1:0]               res_bid_r, res_bid_nxt;
  logic [pcbw_pkg::CNT_OUT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [ID_W-1:0]               out_bid_r, out_bid_nxt;
  logic [pcbw_pkg::CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  // RAM ports
  logic              id_we;
  logic [ADDR_W-1:0] id_wr_addr;
  logic [ADDR_W-1:0] id_rd_addr;
  logic [ID_W-1:0]   id_rdata;
  logic              meta_we;
  logic [SLOT_W-1:0] meta_wr_addr;
  logic [META_W-1:0] meta_wdata;
  logic [SLOT_W-1:0] meta_rd_addr;
  logic [META_W-1:0] meta_rdata;

  // Store arithmetic
  logic [PTR_W-1:0] m_ptr;
  logic [CNT_W-1:0] m_cnt;
  logic [CNT_W-1:0] limit;
  logic             full;
  logic [PTR_W-1:0] wpos, ptr1, ptr2;
  logic [CNT_W-1:0] cnt1, cnt2, drop;
  logic             hit;

  pcbw_ram #(
    .WIDTH (ID_W),
    .DEPTH (ID_DEPTH)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (id_we),
    .wr_addr (id_wr_addr),
    .wr_data (id_r),
    .rd_addr (id_rd_addr),
    .rd_data (id_rdata)
  );

  pcbw_ram #(
    .WIDTH (META_W),
    .DEPTH (CLIENT_SLOTS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wdata),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_rdata)
  );

  // Per-client window state as read back for the current request
  assign m_ptr = meta_rdata[META_W-1:CNT_W];
  assign m_cnt = meta_rdata[CNT_W-1:0];

  // Effective limit: clamp to the window depth
  assign limit = (32'(cfg_max_r) > WINDOW_DEPTH) ? CNT_W'(WINDOW_DEPTH)
                                                 : CNT_W'(cfg_max_r);

  // Append position and pointer/count after the append, then trim to limit
  assign full = (m_cnt == CNT_W'(WINDOW_DEPTH));
  assign wpos = full ? m_ptr : wrap_pos(SUM_W'(m_ptr) + SUM_W'(m_cnt));
  assign ptr1 = full ? wrap_pos(SUM_W'(m_ptr) + SUM_W'(1)) : m_ptr;
  assign cnt1 = full ? m_cnt : m_cnt + CNT_W'(1);
  assign drop = (cnt1 > limit) ? cnt1 - limit : '0;
  assign ptr2 = wrap_pos(SUM_W'(ptr1) + SUM_W'(drop));
  assign cnt2 = (cnt1 > limit) ? limit : cnt1;

  // Search unit compare: data in id_rdata is valid once one read is issued
  assign hit = (k_r != '0) && (id_rdata == id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcbw_pkg::ST_INIT;
      init_r      <= '0;
      cfg_max_r   <= pcbw_pkg::CFG_MAX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_max_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    slot_r      <= slot_nxt;
    id_r        <= id_nxt;
    ok_r        <= ok_nxt;
    base_r      <= base_nxt;
    ptr_r       <= ptr_nxt;
    cnt_r       <= cnt_nxt;
    k_r         <= k_nxt;
    res_found_r <= res_found_nxt;
    res_bid_r   <= res_bid_nxt;
    res_cnt_r   <= res_cnt_nxt;
    out_found_r <= out_found_nxt;
    out_bid_r   <= out_bid_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    id_nxt        = id_r;
    ok_nxt        = ok_r;
    base_nxt      = base_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    res_found_nxt = res_found_r;
    res_bid_nxt   = res_bid_r;
    res_cnt_nxt   = res_cnt_r;
    out_found_nxt = out_found_r;
    out_bid_nxt   = out_bid_r;
    out_cnt_nxt   = out_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;

    in_tready    = 1'b0;
    id_we        = 1'b0;
    id_wr_addr   = base_r + ADDR_W'(wpos);
    id_rd_addr   = base_r;
    meta_we      = 1'b0;
    meta_wr_addr = slot_r;
    meta_wdata   = '0;
    meta_rd_addr = SLOT_W'(in_client);

    case (state_r)
      pcbw_pkg::ST_INIT: begin
        // Sweep every client slot to an empty window
        meta_we      = 1'b1;
        meta_wr_addr = init_r;
        init_nxt     = init_r + SLOT_W'(1);
        if (init_r == SLOT_W'(CLIENT_SLOTS - 1)) begin
          state_nxt = pcbw_pkg::ST_IDLE;
        end
      end

      pcbw_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_opcode;
          slot_nxt  = SLOT_W'(in_client);
          id_nxt    = in_snapshot_id;
          ok_nxt    = (32'(in_client) < CLIENT_SLOTS);
          base_nxt  = ADDR_W'(32'(SLOT_W'(in_client)) * WINDOW_DEPTH);
          state_nxt = pcbw_pkg::ST_META;
        end
      end

      pcbw_pkg::ST_META: begin
        ptr_nxt       = m_ptr;
        cnt_nxt       = m_cnt;
        k_nxt         = '0;
        res_found_nxt = 1'b0;
        res_bid_nxt   = '0;
        res_cnt_nxt   = pcbw_pkg::CNT_OUT_W'(m_cnt);
        state_nxt     = pcbw_pkg::ST_DONE;
        if (!ok_r) begin
          // Slot beyond the table: empty, ignores every operation
          res_cnt_nxt = '0;
        end else begin
          case (op_r)
            pcbw_pkg::OP_STORE: begin
              id_we       = 1'b1;
              meta_we     = 1'b1;
              meta_wdata  = {ptr2, cnt2};
              res_cnt_nxt = pcbw_pkg::CNT_OUT_W'(cnt2);
            end
            pcbw_pkg::OP_DECIDE, pcbw_pkg::OP_FIND: begin
              // Decide never matches a zero id
              if ((m_cnt != '0) &&
                  !((op_r == pcbw_pkg::OP_DECIDE) && (id_r == '0))) begin
                state_nxt = pcbw_pkg::ST_SCAN;
              end
            end
            pcbw_pkg::OP_LATEST: begin
              if (m_cnt != '0) begin
                id_rd_addr = base_r + ADDR_W'(wrap_pos(SUM_W'(m_ptr) + SUM_W'(m_cnt)
                                                       - SUM_W'(1)));
                state_nxt  = pcbw_pkg::ST_LATEST;
              end
            end
            pcbw_pkg::OP_CLEAR: begin
              meta_we     = 1'b1;
              meta_wdata  = '0;
              res_cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      pcbw_pkg::ST_SCAN: begin
        // Issue one read per cycle, compare the one issued the cycle before
        if (hit) begin
          res_found_nxt = 1'b1;
          res_bid_nxt   = id_r;
          state_nxt     = pcbw_pkg::ST_DONE;
        end else if (k_r == cnt_r) begin
          state_nxt = pcbw_pkg::ST_DONE;
        end else begin
          id_rd_addr = base_r + ADDR_W'(wrap_pos(SUM_W'(ptr_r) + SUM_W'(k_r)));
          k_nxt      = k_r + CNT_W'(1);
        end
      end

      pcbw_pkg::ST_LATEST: begin
        res_found_nxt = 1'b1;
        res_bid_nxt   = id_rdata;
        state_nxt     = pcbw_pkg::ST_DONE;
      end

      pcbw_pkg::ST_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_found_nxt = res_found_r;
          out_bid_nxt   = res_bid_r;
          out_cnt_nxt   = res_cnt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pcbw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pcbw_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_bid_r, out_found_r};

endmodule

// ===== hw/rtl/pcbw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pcbw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
